[sv/three_level_priority_queue_assert.svh]
// Assertion macros used by the priority queue datapath.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, switched off while reset is held.
`define TLPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define TLPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TLPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define TLPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/tlpq_pkg.sv]
// Types and constants shared by the priority queue modules.
package tlpq_pkg;

    localparam int ID_W     = 16;
    localparam int NAME_W   = 32;
    localparam int ENTRY_W  = ID_W + NAME_W;
    localparam int NUM_CLASS = 3;

    typedef enum logic [1:0]
    {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_LIST = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_CLASS = 2'd3
    } status_t;

    // Source of the fields loaded into the result register.
    typedef enum logic [1:0]
    {
        RES_PUSH  = 2'd0,
        RES_EMPTY = 2'd1,
        RES_TOP   = 2'd2,
        RES_WALK  = 2'd3
    } res_kind_t;

    typedef struct packed
    {
        logic      latch_req;
        logic      rd_top;
        logic      rd_walk;
        logic      load_out;
        res_kind_t res_kind;
        status_t   out_status;
        logic      out_last;
        logic      do_push;
        logic      do_pop;
        logic      walk_start;
        logic      walk_skip;
        logic      walk_step;
    } dp_cmd_t;

    typedef struct packed
    {
        cmd_t req_cmd;
        logic class_bad;
        logic class_full;
        logic all_empty;
        logic total_one;
        logic remain_one;
        logic walk_hit;
        logic out_free;
    } dp_sts_t;

endpackage

[sv/tlpq_if.sv]
// Request and result channel interfaces of the priority queue.
interface tlpq_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [1:0]                  class_sel;
    logic [tlpq_pkg::ID_W-1:0]   entry_id;
    logic [tlpq_pkg::NAME_W-1:0] entry_name;

    modport source (output valid, output cmd, output class_sel, output entry_id,
                    output entry_name, input ready);
    modport sink   (input valid, input cmd, input class_sel, input entry_id,
                    input entry_name, output ready);
endinterface

interface tlpq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [1:0]                  out_class;
    logic [tlpq_pkg::ID_W-1:0]   out_id;
    logic [tlpq_pkg::NAME_W-1:0] out_name;
    logic                        last;

    modport source (output valid, output status, output out_class, output out_id,
                    output out_name, output last, input ready);
    modport sink   (input valid, input status, input out_class, input out_id,
                    input out_name, input last, output ready);
endinterface

[sv/tlpq_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
module tlpq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tlpq_pkg::dp_sts_t sts,
    output tlpq_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.res_kind   = tlpq_pkg::RES_EMPTY;
        cmd.out_status = tlpq_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                // The head of the top class is read every idle cycle, so the
                // data is ready when a pop or peek arrives.
                in_ready   = 1'b1;
                cmd.rd_top = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                    case (sts.req_cmd)
                        tlpq_pkg::CMD_PUSH:
                        begin
                            cmd.res_kind = tlpq_pkg::RES_PUSH;
                            if (sts.class_bad)
                            begin
                                cmd.out_status = tlpq_pkg::ST_BAD_CLASS;
                            end
                            else if (sts.class_full)
                            begin
                                cmd.out_status = tlpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.do_push = 1'b1;
                            end
                        end
                        tlpq_pkg::CMD_POP, tlpq_pkg::CMD_PEEK:
                        begin
                            if (sts.all_empty)
                            begin
                                cmd.out_status = tlpq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.res_kind = tlpq_pkg::RES_TOP;
                                cmd.do_pop   = (sts.req_cmd == tlpq_pkg::CMD_POP);
                            end
                        end
                        tlpq_pkg::CMD_LIST:
                        begin
                            if (sts.all_empty)
                            begin
                                cmd.out_status = tlpq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.res_kind = tlpq_pkg::RES_TOP;
                                cmd.out_last = sts.total_one;
                                if (!sts.total_one)
                                begin
                                    cmd.walk_start = 1'b1;
                                    state_next     = S_WALK;
                                end
                            end
                        end
                        default:
                        begin
                            cmd.out_status = tlpq_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (sts.walk_hit)
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.walk_skip = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.res_kind  = tlpq_pkg::RES_WALK;
                    cmd.out_last  = sts.remain_one;
                    cmd.walk_step = 1'b1;
                    state_next    = sts.remain_one ? S_IDLE : S_WALK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/tlpq_dp.sv]
// Datapath: class queues, entry memory, list walker and result register.
`include "three_level_priority_queue_assert.svh"

module tlpq_dp #(
    parameter int DEPTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlpq_pkg::dp_cmd_t           cmd,
    output tlpq_pkg::dp_sts_t           sts,
    input  logic [1:0]                  req_cmd,
    input  logic [1:0]                  req_class,
    input  logic [tlpq_pkg::ID_W-1:0]   req_id,
    input  logic [tlpq_pkg::NAME_W-1:0] req_name,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_status,
    output logic [1:0]                  out_class,
    output logic [tlpq_pkg::ID_W-1:0]   out_id,
    output logic [tlpq_pkg::NAME_W-1:0] out_name,
    output logic                        out_last
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int TOT_W  = $clog2(3 * DEPTH + 1);
    localparam int MEM_D  = 3 * DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    // Latched request.
    tlpq_pkg::cmd_t              cmd_reg;
    logic [1:0]                  class_reg;
    logic [tlpq_pkg::ID_W-1:0]   id_reg;
    logic [tlpq_pkg::NAME_W-1:0] name_reg;

    // Queue bookkeeping, one set per class.
    logic [CNT_W-1:0] fill_reg [3];
    logic [PTR_W-1:0] head_reg [3];
    logic [PTR_W-1:0] tail_reg [3];

    // List walker.
    logic [1:0]       walk_cls_reg;
    logic [CNT_W-1:0] walk_idx_reg;
    logic [TOT_W-1:0] remain_reg;

    // Entry memory: id in the upper bits, name handle in the lower bits.
    logic [tlpq_pkg::ENTRY_W-1:0] mem [MEM_D];
    logic [tlpq_pkg::ENTRY_W-1:0] rdata_reg;

    // Result register.
    logic                        out_valid_reg;
    tlpq_pkg::status_t           out_status_reg;
    logic [1:0]                  out_class_reg;
    logic [tlpq_pkg::ID_W-1:0]   out_id_reg;
    logic [tlpq_pkg::NAME_W-1:0] out_name_reg;
    logic                        out_last_reg;

    logic [1:0]       top_cls;
    logic [1:0]       push_cls;
    logic [CNT_W-1:0] push_fill;
    logic [PTR_W-1:0] push_tail;
    logic [PTR_W-1:0] top_head;
    logic [CNT_W-1:0] walk_fill;
    logic [PTR_W-1:0] walk_head;
    logic [TOT_W-1:0] total;
    logic [SUM_W-1:0] slot_sum;
    logic [PTR_W-1:0] walk_slot;
    logic [ADDR_W-1:0] top_base;
    logic [ADDR_W-1:0] walk_base;
    logic [ADDR_W-1:0] push_base;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              out_free;
    logic              fill_in_range;
    logic              push_legal;

    function automatic logic [ADDR_W-1:0] class_base(input logic [1:0] c);
        logic [ADDR_W-1:0] b;
        case (c)
            2'd1:    b = ADDR_W'(DEPTH);
            2'd2:    b = ADDR_W'(2 * DEPTH);
            default: b = '0;
        endcase
        return b;
    endfunction

    assign top_cls  = (fill_reg[0] != '0) ? 2'd0 : ((fill_reg[1] != '0) ? 2'd1 : 2'd2);
    assign push_cls = class_reg - 2'd1;
    assign total    = TOT_W'(fill_reg[0]) + TOT_W'(fill_reg[1]) + TOT_W'(fill_reg[2]);

    always_comb
    begin
        case (push_cls)
            2'd0:
            begin
                push_fill = fill_reg[0];
                push_tail = tail_reg[0];
            end
            2'd1:
            begin
                push_fill = fill_reg[1];
                push_tail = tail_reg[1];
            end
            2'd2:
            begin
                push_fill = fill_reg[2];
                push_tail = tail_reg[2];
            end
            default:
            begin
                push_fill = '0;
                push_tail = '0;
            end
        endcase
    end

    always_comb
    begin
        case (top_cls)
            2'd0:    top_head = head_reg[0];
            2'd1:    top_head = head_reg[1];
            2'd2:    top_head = head_reg[2];
            default: top_head = '0;
        endcase
    end

    always_comb
    begin
        case (walk_cls_reg)
            2'd0:
            begin
                walk_fill = fill_reg[0];
                walk_head = head_reg[0];
            end
            2'd1:
            begin
                walk_fill = fill_reg[1];
                walk_head = head_reg[1];
            end
            2'd2:
            begin
                walk_fill = fill_reg[2];
                walk_head = head_reg[2];
            end
            default:
            begin
                walk_fill = '0;
                walk_head = '0;
            end
        endcase
    end

    // Both terms stay below DEPTH, so one subtract folds the slot back.
    assign slot_sum  = SUM_W'(walk_head) + SUM_W'(walk_idx_reg);
    assign walk_slot = (slot_sum >= SUM_W'(DEPTH)) ? PTR_W'(slot_sum - SUM_W'(DEPTH))
                                                    : PTR_W'(slot_sum);

    assign top_base  = class_base(top_cls);
    assign walk_base = class_base(walk_cls_reg);
    assign push_base = class_base(push_cls);
    assign raddr     = cmd.rd_walk ? (walk_base + ADDR_W'(walk_slot))
                                   : (top_base + ADDR_W'(top_head));
    assign waddr     = push_base + ADDR_W'(push_tail);

    assign out_free = !out_valid_reg || out_ready;

    assign sts.req_cmd    = cmd_reg;
    assign sts.class_bad  = (class_reg == 2'd0);
    assign sts.class_full = (push_fill == CNT_W'(DEPTH));
    assign sts.all_empty  = (total == '0);
    assign sts.total_one  = (total == TOT_W'(1));
    assign sts.remain_one = (remain_reg == TOT_W'(1));
    assign sts.walk_hit   = (walk_idx_reg < walk_fill);
    assign sts.out_free   = out_free;

    assign fill_in_range = (fill_reg[0] <= CNT_W'(DEPTH)) && (fill_reg[1] <= CNT_W'(DEPTH))
                           && (fill_reg[2] <= CNT_W'(DEPTH));
    assign push_legal    = !sts.class_full && !sts.class_bad;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            cmd_reg   <= tlpq_pkg::cmd_t'(req_cmd);
            class_reg <= req_class;
            id_reg    <= req_id;
            name_reg  <= req_name;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
        begin
            mem[waddr] <= {id_reg, name_reg};
        end
        if (cmd.rd_top || cmd.rd_walk)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                fill_reg[k] <= '0;
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (cmd.do_push && (push_cls == 2'(k)))
                begin
                    fill_reg[k] <= fill_reg[k] + 1'b1;
                    tail_reg[k] <= (tail_reg[k] == PTR_W'(DEPTH - 1)) ? '0
                                                                       : tail_reg[k] + 1'b1;
                end
                if (cmd.do_pop && (top_cls == 2'(k)))
                begin
                    fill_reg[k] <= fill_reg[k] - 1'b1;
                    head_reg[k] <= (head_reg[k] == PTR_W'(DEPTH - 1)) ? '0
                                                                       : head_reg[k] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cls_reg <= '0;
            walk_idx_reg <= '0;
            remain_reg   <= '0;
        end
        else if (cmd.walk_start)
        begin
            walk_cls_reg <= top_cls;
            walk_idx_reg <= CNT_W'(1);
            remain_reg   <= total - 1'b1;
        end
        else if (cmd.walk_skip)
        begin
            walk_cls_reg <= walk_cls_reg + 2'd1;
            walk_idx_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
            remain_reg   <= remain_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_last_reg <= cmd.out_last;
            case (cmd.res_kind)
                tlpq_pkg::RES_PUSH:
                begin
                    out_status_reg <= cmd.out_status;
                    out_class_reg  <= class_reg;
                    out_id_reg     <= '0;
                    out_name_reg   <= '0;
                end
                tlpq_pkg::RES_TOP:
                begin
                    out_status_reg <= tlpq_pkg::ST_OK;
                    out_class_reg  <= top_cls + 2'd1;
                    out_id_reg     <= rdata_reg[tlpq_pkg::ENTRY_W-1:tlpq_pkg::NAME_W];
                    out_name_reg   <= rdata_reg[tlpq_pkg::NAME_W-1:0];
                end
                tlpq_pkg::RES_WALK:
                begin
                    out_status_reg <= tlpq_pkg::ST_OK;
                    out_class_reg  <= walk_cls_reg + 2'd1;
                    out_id_reg     <= rdata_reg[tlpq_pkg::ENTRY_W-1:tlpq_pkg::NAME_W];
                    out_name_reg   <= rdata_reg[tlpq_pkg::NAME_W-1:0];
                end
                default:
                begin
                    out_status_reg <= tlpq_pkg::ST_EMPTY;
                    out_class_reg  <= '0;
                    out_id_reg     <= '0;
                    out_name_reg   <= '0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_class  = out_class_reg;
    assign out_id     = out_id_reg;
    assign out_name   = out_name_reg;
    assign out_last   = out_last_reg;

    `TLPQ_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_in_range, "fill count above DEPTH")
    `TLPQ_ASSERT_IMP(a_push_legal, clk, rst_n, cmd.do_push, push_legal, "illegal push written")
    `TLPQ_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.do_pop, !sts.all_empty, "pop while empty")
    `TLPQ_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_out, out_free, "result overwritten")
    `TLPQ_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid_reg, "result not shown")

endmodule

[sv/three_level_priority_queue.sv]
// Top level of the three-class strict-priority queue.
//
// Requests arrive on the request channel (cmd, class_sel, entry_id, entry_name) and
// results leave on the result channel (status, out_class, out_id, out_name, last);
// both use a valid/ready handshake and a request is taken when both are high.
// Push appends to the queue of its class, pop and peek report the oldest entry of
// the highest class that holds one, and list reports every stored entry, class 1
// first, with last set on the final result of the request.
// Push, pop, peek and every request that finds the queues empty give their single
// result from the result register, and no new request is taken until the controller
// is back in idle. List gives its first entry from the head read, then fetches each
// further entry before registering it, with an extra step each time the walk moves
// on from one class to the next, because each entry is fetched through the single
// read port of the entry memory. The next request is taken once the final result is
// registered.
// A single result register sits on the output: while the receiver stalls, the block
// may still take the next request, but it waits before overwriting a pending result.
// Reset empties all three queues at once; the entry memory needs no clearing, since
// only slots holding a pushed entry are ever reported.
module three_level_priority_queue #(
    parameter int DEPTH = 16
)
(
    input logic        clk,
    input logic        rst_n,
    tlpq_req_if.sink   request,
    tlpq_rsp_if.source result
);

    tlpq_pkg::dp_cmd_t dp_cmd;
    tlpq_pkg::dp_sts_t dp_sts;
    logic              in_ready;

    // The controller owns the request handshake and steps the datapath.
    tlpq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // The datapath holds the queues, the entry memory and the result register.
    tlpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .req_cmd    (request.cmd),
        .req_class  (request.class_sel),
        .req_id     (request.entry_id),
        .req_name   (request.entry_name),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_status (result.status),
        .out_class  (result.out_class),
        .out_id     (result.out_id),
        .out_name   (result.out_name),
        .out_last   (result.last)
    );

    assign request.ready = in_ready;

endmodule
